// ===== rtl/pwd_pkg.sv =====
// ----------------------------------------------------------------------------
// pwd_pkg
// Shared types and constants for the periodic within-distance test unit.
// ----------------------------------------------------------------------------
package pwd_pkg;

    localparam int unsigned MaxSelectionDefault = 256;
    localparam int unsigned CoordW = 24;
    localparam int unsigned LenW   = 23;
    localparam int unsigned SqW    = 2 * CoordW;
    localparam int unsigned AccW   = SqW + 2;
    localparam int unsigned CfgIdxW = 2;

    typedef enum logic [CfgIdxW-1:0] {
        REG_BOX_LEN_X = 2'd0,
        REG_BOX_LEN_Y = 2'd1,
        REG_BOX_LEN_Z = 2'd2,
        REG_CUTOFF    = 2'd3
    } cfg_reg_t;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef struct packed {
        logic                     op;
        logic                     new_set;
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic signed [CoordW-1:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic within_res;
        logic set_overflow;
    } out_item_t;

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
    } point_t;

endpackage

// ===== rtl/pwd_ram.sv =====
// ----------------------------------------------------------------------------
// pwd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pwd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/pwd_rem.sv =====
// ----------------------------------------------------------------------------
// pwd_rem
// Bit-serial remainder unit folding one axis distance to its minimum image.
// ----------------------------------------------------------------------------
module pwd_rem
    import pwd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CoordW-1:0] mag,
    input  logic [LenW-1:0]   len,
    output logic              done,
    output logic [CoordW-1:0] res
);

    localparam int unsigned CntW = $clog2(CoordW);

    logic              busy_reg;
    logic              done_reg;
    logic [CntW-1:0]   cnt_reg;
    logic [CoordW-1:0] rem_reg;
    logic [CoordW-1:0] rem_next;
    logic [CoordW-1:0] mag_reg;
    logic [LenW-1:0]   len_reg;
    logic [CoordW-1:0] trial;
    logic [CoordW:0]   rem_x2;

    assign trial = {rem_reg[CoordW-2:0], mag_reg[CoordW-1]};

    always_comb
    begin
        if (trial >= {1'b0, len_reg})
        begin
            rem_next = trial - {1'b0, len_reg};
        end
        else
        begin
            rem_next = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(CoordW - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            mag_reg <= mag;
            len_reg <= len;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            mag_reg <= {mag_reg[CoordW-2:0], 1'b0};
        end
    end

    // round half away from zero: take the far side when 2*rem >= len
    assign rem_x2 = {rem_reg, 1'b0};
    assign done   = done_reg;

    always_comb
    begin
        if (len_reg == '0 || rem_x2 < {2'b00, len_reg})
        begin
            res = rem_reg;
        end
        else
        begin
            res = {1'b0, len_reg} - rem_reg;
        end
    end

endmodule

// ===== rtl/periodic_within_distance_test_unit.sv =====
// ----------------------------------------------------------------------------
// periodic_within_distance_test_unit
// Stores selection points and tests points against them under periodic
// boundaries with a squared-cutoff compare.
// ----------------------------------------------------------------------------
// A load beat (op = 0) produces no result; in_ready stays high. A test beat
// (op = 1) walks the stored points one at a time, and each axis of each pair
// runs through one shared bit-serial remainder unit, followed by a square and
// an accumulate state. A test stops at the first point within the cutoff and
// goes straight to its result on an empty set. in_ready is low while a test
// runs. The result beat waits in an output register, so new loads are taken
// while it is pending.
// ----------------------------------------------------------------------------
module periodic_within_distance_test_unit
    import pwd_pkg::*;
#(
    parameter int unsigned MAX_SELECTION = MaxSelectionDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_data,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [LenW-1:0]    cfg_data
);

    localparam int unsigned AddrW = (MAX_SELECTION > 1) ? $clog2(MAX_SELECTION) : 1;
    localparam int unsigned CntW  = $clog2(MAX_SELECTION + 1);
    localparam int unsigned PtW   = $bits(point_t);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_DIV  = 6'b000100,
        S_SQ   = 6'b001000,
        S_ACC  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [LenW-1:0]   box_x_reg;
    logic [LenW-1:0]   box_y_reg;
    logic [LenW-1:0]   box_z_reg;
    logic [LenW-1:0]   cutoff_reg;
    logic [CntW-1:0]   count_reg;
    logic              ovf_reg;
    logic [CntW-1:0]   idx_reg;
    logic [1:0]        axis_reg;
    point_t            test_reg;
    logic [AccW-1:0]   acc_reg;
    logic [SqW-1:0]    lim_reg;
    logic [CoordW-1:0] r_reg;
    logic [SqW-1:0]    sq_reg;
    logic              hit_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic              accept;
    logic              do_load;
    logic [CntW-1:0]   load_count;
    logic              full;
    logic              ram_we;
    logic              ram_re;
    logic [CntW-1:0]   rd_idx;
    point_t            sel_pt;
    logic [PtW-1:0]    ram_rdata;
    logic              rem_start;
    logic              rem_done;
    logic [CoordW-1:0] rem_res;
    logic signed [CoordW:0] diff;
    logic [CoordW:0]   diff_abs;
    logic [CoordW-1:0] mag;
    logic [LenW-1:0]   len;
    logic [AccW-1:0]   acc_sum;
    logic              last_pt;
    logic              can_out;
    logic [1:0]        axis_sel;
    logic [2*LenW-1:0] cut_sq;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign do_load  = accept && (in_data.op == OP_LOAD);
    assign load_count = in_data.new_set ? '0 : count_reg;
    assign full     = (load_count == CntW'(MAX_SELECTION));
    assign ram_we   = do_load && !full;
    assign sel_pt   = point_t'(ram_rdata);
    assign acc_sum  = acc_reg + AccW'(sq_reg);
    assign last_pt  = ((idx_reg + 1'b1) == count_reg);
    assign can_out  = !out_valid_reg || out_ready;
    assign axis_sel = (state_reg == S_ACC) ? axis_reg + 2'd1 : 2'd0;
    assign cut_sq   = cutoff_reg * cutoff_reg;

    pwd_ram #(
        .WIDTH(PtW),
        .DEPTH(MAX_SELECTION)
    ) u_sel_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(load_count[AddrW-1:0]),
        .wdata({in_data.pos_x, in_data.pos_y, in_data.pos_z}),
        .re   (ram_re),
        .raddr(rd_idx[AddrW-1:0]),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        unique case (axis_sel)
            2'd0:
            begin
                diff = {test_reg.x[CoordW-1], test_reg.x} - {sel_pt.x[CoordW-1], sel_pt.x};
                len  = box_x_reg;
            end
            2'd1:
            begin
                diff = {test_reg.y[CoordW-1], test_reg.y} - {sel_pt.y[CoordW-1], sel_pt.y};
                len  = box_y_reg;
            end
            default:
            begin
                diff = {test_reg.z[CoordW-1], test_reg.z} - {sel_pt.z[CoordW-1], sel_pt.z};
                len  = box_z_reg;
            end
        endcase
    end

    assign diff_abs = diff[CoordW] ? (CoordW + 1)'(-diff) : diff;
    assign mag      = diff_abs[CoordW-1:0];

    pwd_rem u_rem (
        .clk  (clk),
        .rst_n(rst_n),
        .start(rem_start),
        .mag  (mag),
        .len  (len),
        .done (rem_done),
        .res  (rem_res)
    );

    always_comb
    begin
        state_next = state_reg;
        ram_re     = 1'b0;
        rd_idx     = idx_reg;
        rem_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && in_data.op == OP_TEST)
                begin
                    rd_idx = '0;
                    if (count_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                rem_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (rem_done)
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (axis_reg != 2'd2)
                begin
                    rem_start  = 1'b1;
                    state_next = S_DIV;
                end
                else if (acc_sum <= AccW'(lim_reg) || last_pt)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_idx     = idx_reg + 1'b1;
                    ram_re     = 1'b1;
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                if (can_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            box_x_reg     <= LenW'(4096);
            box_y_reg     <= LenW'(4096);
            box_z_reg     <= LenW'(4096);
            cutoff_reg    <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_BOX_LEN_X: box_x_reg  <= cfg_data;
                    REG_BOX_LEN_Y: box_y_reg  <= cfg_data;
                    REG_BOX_LEN_Z: box_z_reg  <= cfg_data;
                    REG_CUTOFF:    cutoff_reg <= cfg_data;
                    default:       cutoff_reg <= cutoff_reg;
                endcase
            end
            if (do_load)
            begin
                if (full)
                begin
                    count_reg <= load_count;
                    ovf_reg   <= 1'b1;
                end
                else
                begin
                    count_reg <= load_count + 1'b1;
                    ovf_reg   <= in_data.new_set ? 1'b0 : ovf_reg;
                end
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_DONE && can_out)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_data.op == OP_TEST)
        begin
            test_reg <= '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z};
            lim_reg  <= SqW'(cut_sq);
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
        end
        if (state_reg == S_RD)
        begin
            axis_reg <= 2'd0;
            acc_reg  <= '0;
        end
        if (state_reg == S_DIV && rem_done)
        begin
            r_reg <= rem_res;
        end
        if (state_reg == S_SQ)
        begin
            sq_reg <= r_reg * r_reg;
        end
        if (state_reg == S_ACC)
        begin
            acc_reg  <= acc_sum;
            axis_reg <= axis_reg + 1'b1;
            if (axis_reg == 2'd2)
            begin
                idx_reg <= idx_reg + 1'b1;
                hit_reg <= (acc_sum <= AccW'(lim_reg));
            end
        end
        if (state_reg == S_DONE && can_out)
        begin
            out_data_reg <= '{within_res: hit_reg, set_overflow: ovf_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/pwd_chk.sv =====
// ----------------------------------------------------------------------------
// pwd_chk
// Port-level checks for the periodic within-distance test unit.
// ----------------------------------------------------------------------------
module pwd_chk
    import pwd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat dropped or changed while stalled");

    a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.op == OP_TEST |=> !in_ready)
        else $error("ready after test beat");

    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.op == OP_LOAD |=> in_ready)
        else $error("ready dropped after load beat");

    a_out_after_test: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result beat without a running test");

endmodule

bind periodic_within_distance_test_unit pwd_chk u_pwd_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
);

// ===== sim/pwd_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwd_checker
// Watches the input and result channels of the periodic within-distance unit,
// keeps its own copy of the selection and the cell setup, computes the
// within mark and overflow flag for each accepted test beat and compares the
// result beats against them in order.
// ----------------------------------------------------------------------------
module pwd_checker
    import pwd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  in_item_t           in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  out_item_t          out_data,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [LenW-1:0]    cfg_data,
    output int                 fail_count,
    output int                 pending_marks,
    output int                 marks_seen
);

    localparam int unsigned Depth = 256;
    localparam int unsigned IdxW  = $clog2(Depth);

    point_t          sel_pts[Depth];
    int unsigned     sel_num;
    logic            ovf_seen;
    logic [LenW-1:0] len_x;
    logic [LenW-1:0] len_y;
    logic [LenW-1:0] len_z;
    logic [LenW-1:0] cut_len;
    out_item_t       mark_queue[$];

    function automatic longint unsigned image_sq(logic signed [CoordW-1:0] a,
                                                 logic signed [CoordW-1:0] b,
                                                 logic [LenW-1:0] len);
        longint          d;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned ql;
        longint unsigned r;
        d   = longint'(a) - longint'(b);
        mag = (d < 0) ? longint'(-d) : longint'(d);
        r   = mag;
        if (len != 0)
        begin
            q  = (2 * mag + len) / (2 * longint'(len));
            ql = q * len;
            r  = (ql >= mag) ? ql - mag : mag - ql;
        end
        return r * r;
    endfunction

    function automatic out_item_t within_mark(in_item_t t);
        out_item_t       m;
        longint unsigned lim;
        longint unsigned dr;
        lim = longint'(cut_len) * longint'(cut_len);
        m.within_res   = 1'b0;
        m.set_overflow = ovf_seen;
        for (int i = 0; i < sel_num; i++)
        begin
            dr = image_sq(t.pos_x, sel_pts[IdxW'(i)].x, len_x)
               + image_sq(t.pos_y, sel_pts[IdxW'(i)].y, len_y)
               + image_sq(t.pos_z, sel_pts[IdxW'(i)].z, len_z);
            if (dr <= lim)
            begin
                m.within_res = 1'b1;
                break;
            end
        end
        return m;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        int        errs;
        errs = 0;
        if (!rst_n)
        begin
            sel_num       <= 0;
            ovf_seen      <= 1'b0;
            len_x         <= 23'd4096;
            len_y         <= 23'd4096;
            len_z         <= 23'd4096;
            cut_len       <= '0;
            fail_count    <= 0;
            marks_seen    <= 0;
            pending_marks <= 0;
            mark_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_BOX_LEN_X: len_x   <= cfg_data;
                    REG_BOX_LEN_Y: len_y   <= cfg_data;
                    REG_BOX_LEN_Z: len_z   <= cfg_data;
                    REG_CUTOFF:    cut_len <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                marks_seen <= marks_seen + 1;
                if (mark_queue.size() == 0)
                begin
                    $error("result beat with nothing expected: %p", out_data);
                    errs++;
                end
                else
                begin
                    e = mark_queue.pop_front();
                    if (e.within_res !== out_data.within_res)
                    begin
                        $error("within_res expected %0b actual %0b",
                               e.within_res, out_data.within_res);
                        errs++;
                    end
                    if (e.set_overflow !== out_data.set_overflow)
                    begin
                        $error("set_overflow expected %0b actual %0b",
                               e.set_overflow, out_data.set_overflow);
                        errs++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (in_data.op == OP_TEST)
                    mark_queue.insert(mark_queue.size(), within_mark(in_data));
                else
                begin
                    if (in_data.new_set)
                    begin
                        sel_pts[0] <= '{in_data.pos_x, in_data.pos_y, in_data.pos_z};
                        sel_num    <= 1;
                        ovf_seen   <= 1'b0;
                    end
                    else if (sel_num < Depth)
                    begin
                        sel_pts[IdxW'(sel_num)] <= '{in_data.pos_x, in_data.pos_y,
                                                     in_data.pos_z};
                        sel_num                 <= sel_num + 1;
                    end
                    else
                        ovf_seen <= 1'b1;
                end
            end
            fail_count    <= fail_count + errs;
            pending_marks <= mark_queue.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and test beats into the periodic within-distance unit over
// several cell and cutoff setups, with random gaps and result stalls; the
// checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
    import pwd_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_ready;
    out_item_t          out_data;
    logic               cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [LenW-1:0]    cfg_data;
    int                 fail_count;
    int                 pending_marks;
    int                 marks_seen;
    int                 beats_sent;

    periodic_within_distance_test_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pwd_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_marks (pending_marks),
        .marks_seen    (marks_seen)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // stall the result side for a random number of cycles per beat
    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_beat(logic op, logic ns, logic signed [CoordW-1:0] x,
                             logic signed [CoordW-1:0] y,
                             logic signed [CoordW-1:0] z, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{op, ns, x, y, z};
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [LenW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_marks != 0) @(posedge clk);
        repeat (1000) @(posedge clk);
    endtask

    function automatic logic signed [CoordW-1:0] near(logic signed [CoordW-1:0] c,
                                                       int span);
        return CoordW'(c + $signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // random coordinate: full range, or within -16384 to 16383
    function automatic logic signed [CoordW-1:0] rand_coord(bit wide);
        if (wide)
            return CoordW'($urandom());
        return CoordW'($signed($urandom_range(0, 32767)) - 16384);
    endfunction

    initial
    begin
        logic signed [CoordW-1:0] cx, cy, cz;
        logic [LenW-1:0]          lens[6];
        int                       npts;
        bit                       wide;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        beats_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty selection, then extremes with default setup
        send_beat(OP_TEST, 1'b0, 24'sh0, 24'sh0, 24'sh0, 0);
        drain();
        write_reg(REG_CUTOFF, 23'd0);
        send_beat(OP_LOAD, 1'b1, 24'sh7FFFFF, 24'sh800000, 24'sh0, 0);
        send_beat(OP_TEST, 1'b1, 24'sh7FFFFF, 24'sh800000, 24'sh0, 0);
        send_beat(OP_TEST, 1'b0, 24'sh800000, 24'sh7FFFFF, 24'sh001000, 0);
        send_beat(OP_TEST, 1'b0, 24'sh000800, 24'sh0, 24'sh0, 0);
        drain();
        write_reg(REG_BOX_LEN_X, 23'd0);
        write_reg(REG_BOX_LEN_Y, 23'h7FFFFF);
        write_reg(REG_BOX_LEN_Z, 23'd1);
        write_reg(REG_CUTOFF, 23'h7FFFFF);
        send_beat(OP_TEST, 1'b0, 24'sh800000, 24'sh7FFFFF, 24'sh123456, 0);
        send_beat(OP_LOAD, 1'b1, 24'sh000100, 24'sh0, 24'sh0, 0);
        send_beat(OP_TEST, 1'b0, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 0);
        drain();
        // exact cutoff distance, just over, and half-length rounding
        write_reg(REG_BOX_LEN_X, 23'd4096);
        write_reg(REG_BOX_LEN_Y, 23'd0);
        write_reg(REG_BOX_LEN_Z, 23'd0);
        write_reg(REG_CUTOFF, 23'd300);
        send_beat(OP_LOAD, 1'b1, 24'sh0, 24'sh0, 24'sh0, 0);
        send_beat(OP_TEST, 1'b0, 24'sd300, 24'sh0, 24'sh0, 0);
        send_beat(OP_TEST, 1'b0, 24'sd301, 24'sh0, 24'sh0, 0);
        send_beat(OP_TEST, 1'b0, -24'sd3796, 24'sh0, 24'sh0, 0);
        send_beat(OP_TEST, 1'b0, 24'sd2048, 24'sh0, 24'sh0, 0);
        send_beat(OP_TEST, 1'b0, -24'sd2048, 24'sh0, 24'sh0, 0);
        drain();

        // fill the store past capacity, then test the overflow flag
        write_reg(REG_BOX_LEN_Y, 23'd8192);
        write_reg(REG_BOX_LEN_Z, 23'd8192);
        write_reg(REG_CUTOFF, 23'd50);
        for (int i = 0; i < 260; i++)
            send_beat(OP_LOAD, i == 0, CoordW'($urandom()), CoordW'($urandom()),
                      CoordW'($urandom()), 1);
        send_beat(OP_TEST, 1'b0, CoordW'($urandom()), CoordW'($urandom()),
                  CoordW'($urandom()), 0);
        send_beat(OP_LOAD, 1'b1, 24'sh0, 24'sh0, 24'sh0, 0);
        send_beat(OP_TEST, 1'b0, 24'sh0, 24'sh0, 24'sh0, 0);
        drain();

        // random phases: small sets, tests clustered around stored points
        lens = '{23'd4096, 23'd1, 23'h7FFFFF, 23'd0, 23'd1000, 23'd65536};
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(REG_BOX_LEN_X, lens[$urandom_range(0, 5)]);
            write_reg(REG_BOX_LEN_Y, lens[$urandom_range(0, 5)]);
            write_reg(REG_BOX_LEN_Z, lens[$urandom_range(0, 5)]);
            write_reg(REG_CUTOFF,
                      (ph % 4 == 3) ? 23'h7FFFFF : LenW'($urandom_range(0, 3000)));
            wide = (ph % 3 == 2);
            while (beats_sent < 300 + (ph + 1) * 45)
            begin
                npts = $urandom_range(1, 6);
                cx = rand_coord(wide);
                cy = rand_coord(wide);
                cz = rand_coord(wide);
                for (int k = 0; k < npts; k++)
                    send_beat(OP_LOAD, (k == 0) && ($urandom_range(0, 3) != 0),
                              near(cx, 4000), near(cy, 4000), near(cz, 4000),
                              $urandom_range(0, 2) == 0);
                for (int k = 0; k < $urandom_range(1, 5); k++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_beat(OP_TEST, 1'($urandom()), CoordW'($urandom()),
                                  CoordW'($urandom()), CoordW'($urandom()), 0);
                    else
                        send_beat(OP_TEST, 1'($urandom()), near(cx, 5000),
                                  near(cy, 5000), near(cz, 5000),
                                  $urandom_range(0, 2) == 0);
                end
            end
            drain();
        end

        $display("Sent %0d beats over several cell and cutoff setups; %0d results checked.",
                 beats_sent, marks_seen);
        if (fail_count == 0)
            $display("[periodic_within_distance_test_unit] OK");
        else
            $display("[periodic_within_distance_test_unit] ERROR");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("[periodic_within_distance_test_unit] ERROR");
        $finish;
    end

endmodule
